// File: rtl/pru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg: shared definitions for the png row unfilter
// codes for actions, color modes, filter kinds, register indexes and the
// paeth predictor used in the reconstruction stage
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  // configuration port
  localparam int PADDR_W   = 4;
  localparam int CFG_W_W   = 11;   // image_width register bits
  localparam int CFG_CNT_W = 9;    // palette_count register bits

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_COLOR_MODE    = 2'd1;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

  // input word actions
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_PALETTE = 2'd1;
  localparam logic [1:0] ACT_IMAGE   = 2'd2;

  // color modes
  localparam logic [2:0] CM_GRAY  = 3'd0;
  localparam logic [2:0] CM_RGB   = 3'd1;
  localparam logic [2:0] CM_PAL   = 3'd2;
  localparam logic [2:0] CM_GRAYA = 3'd3;
  localparam logic [2:0] CM_RGBA  = 3'd4;

  // filter kinds
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // control carried with a data byte into the reconstruction stage
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       first_row;
    logic       row_start;
    logic [1:0] lsel;       // bytes per pixel minus one
    logic       asm_load;
    logic       asm_shift;
    logic       emit;
    logic       row_end;
    logic [2:0] mode;
  } s1_ctl_t;

  // bytes per pixel minus one
  function automatic logic [1:0] bpp_m1(input logic [2:0] mode);
    logic [1:0] r;
    case (mode)
      CM_RGB:   r = 2'd2;
      CM_GRAYA: r = 2'd1;
      CM_RGBA:  r = 2'd3;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] pa, pb, pc;
    logic [7:0] r;
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc) r = b;
    else r = c;
    return r;
  endfunction

endpackage

// File: rtl/png_row_unfilter_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_to_rgb: png scanline reconstruction to 24-bit rgb
// undoes none/sub/up/average/paeth per row and turns finished pixels into rgb
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+-------------------------
//  in       | in_valid/in_ready, in_action, in_data_  | one stream byte, palette
//           | byte, in_palette_index, in_palette_color| write or image start
//  out      | out_valid/out_ready, out_pixel_rgb,     | one rgb pixel
//           | out_row_end                             |
//  config   | psel/penable/pwrite/paddr/pwdata/prdata | image_width, color_mode,
//           | pready                                  | palette_count
//
//  one input word per cycle while out_ready does not stall the output; a pixel's
//  last byte passes the row store read on the edge that takes it,
//  reconstruction, then the output register before the pixel is valid
//  the rate is set by the left-byte feedback through the predictor, which
//  closes between consecutive bytes because the row store is read when the byte is taken
//  rst_n clears control only; row store and palette hold garbage until written
//  out_ready low holds the output register, then the reconstruction stage,
//  then in_ready; the config port never stalls
//
module png_row_unfilter_to_rgb #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_action,
  input  logic [7:0]                 in_data_byte,
  input  logic [7:0]                 in_palette_index,
  input  logic [23:0]                in_palette_color,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [23:0]                out_pixel_rgb,
  output logic                       out_row_end,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pru_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import pru_pkg::*;

  localparam int DEPTH = 4 * MAX_WIDTH;            // row store bytes
  localparam int POS_W = $clog2(DEPTH);            // row store address
  localparam int STR_W = $clog2(DEPTH + 1);        // row length in bytes
  localparam int EXT_W = (STR_W > CFG_W_W) ? STR_W : CFG_W_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W_W-1:0]   cfg_width_r;
  logic [2:0]           cfg_mode_r;
  logic [CFG_CNT_W-1:0] cfg_count_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r <= CFG_W_W'(1);
      cfg_mode_r  <= CM_RGB;
      cfg_count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:   cfg_width_r <= pwdata[CFG_W_W-1:0];
        REG_COLOR_MODE:    cfg_mode_r  <= pwdata[2:0];
        REG_PALETTE_COUNT: cfg_count_r <= pwdata[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:   prdata = 32'(cfg_width_r);
      REG_COLOR_MODE:    prdata = 32'(cfg_mode_r);
      REG_PALETTE_COUNT: prdata = 32'(cfg_count_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // row geometry: clamp width, bytes per row
  // --------------------------------------------------------------------------
  logic [EXT_W-1:0] w_ext, w_lim;
  logic [STR_W-1:0] w_s, stride;
  logic [1:0]       lsel;

  assign w_ext = EXT_W'(cfg_width_r);
  assign lsel  = bpp_m1(cfg_mode_r);

  always_comb begin
    if (w_ext == '0) w_lim = EXT_W'(1);
    else if (w_ext > EXT_W'(MAX_WIDTH)) w_lim = EXT_W'(MAX_WIDTH);
    else w_lim = w_ext;
  end

  assign w_s = STR_W'(w_lim);

  always_comb begin
    case (lsel)
      2'd1:    stride = w_s << 1;
      2'd2:    stride = w_s + (w_s << 1);
      2'd3:    stride = w_s << 2;
      default: stride = w_s;
    endcase
  end

  // --------------------------------------------------------------------------
  // front end: decode the accepted word, walk the row position
  // --------------------------------------------------------------------------
  logic             await_r, await_nxt;
  logic             first_row_r, first_row_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       bip_r, bip_nxt;

  logic             s1_v_r, s1_v_nxt;
  s1_ctl_t          s1_r, s1_nxt;
  logic [POS_W-1:0] s1_x_r;
  logic             s2_v_r, s2_v_nxt;
  logic             s2_free, s1_fire;

  logic in_acc, data_acc, flt_acc, pal_acc, img_acc;
  logic [STR_W-1:0] x1;
  logic last_row, last_pix, emit;

  assign s2_free  = !s2_v_r || out_ready;
  assign s1_fire  = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;

  assign in_acc   = in_valid && in_ready;
  assign data_acc = in_acc && (in_action == ACT_BYTE) && !await_r;
  assign flt_acc  = in_acc && (in_action == ACT_BYTE) && await_r;
  assign pal_acc  = in_acc && (in_action == ACT_PALETTE);
  assign img_acc  = in_acc && (in_action == ACT_IMAGE);

  assign x1       = STR_W'(pos_r) + STR_W'(1);
  assign last_row = (x1 >= stride);
  assign last_pix = (bip_r >= lsel);
  assign emit     = last_row || last_pix;

  always_comb begin
    await_nxt     = await_r;
    first_row_nxt = first_row_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    bip_nxt       = bip_r;
    if (img_acc) begin
      // fresh image: zero row above, wait for a filter byte
      await_nxt     = 1'b1;
      first_row_nxt = 1'b1;
      kind_nxt      = FLT_NONE;
      pos_nxt       = '0;
      bip_nxt       = '0;
    end else if (flt_acc) begin
      // unknown filter types fall back to none
      kind_nxt  = (in_data_byte <= 8'(FLT_PAETH)) ? in_data_byte[2:0] : FLT_NONE;
      await_nxt = 1'b0;
      pos_nxt   = '0;
      bip_nxt   = '0;
    end else if (data_acc) begin
      bip_nxt = emit ? 2'd0 : bip_r + 2'd1;
      if (last_row) begin
        await_nxt     = 1'b1;
        first_row_nxt = 1'b0;
        pos_nxt       = '0;
      end else begin
        pos_nxt = x1[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r     <= 1'b1;
      first_row_r <= 1'b1;
      kind_r      <= FLT_NONE;
      pos_r       <= '0;
      bip_r       <= '0;
    end else begin
      await_r     <= await_nxt;
      first_row_r <= first_row_nxt;
      kind_r      <= kind_nxt;
      pos_r       <= pos_nxt;
      bip_r       <= bip_nxt;
    end
  end

  // control handed to the reconstruction stage with the byte
  always_comb begin
    s1_nxt.data      = in_data_byte;
    s1_nxt.kind      = kind_r;
    s1_nxt.first_row = first_row_r;
    s1_nxt.row_start = (pos_r == '0);
    s1_nxt.lsel      = lsel;
    s1_nxt.asm_load  = (bip_r == 2'd0);
    s1_nxt.asm_shift = (bip_r != 2'd3) && ((cfg_mode_r == CM_RGB) || (cfg_mode_r == CM_RGBA));
    s1_nxt.emit      = emit;
    s1_nxt.row_end   = last_row;
    s1_nxt.mode      = cfg_mode_r;
  end

  assign s1_v_nxt = data_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);

  // --------------------------------------------------------------------------
  // row store: read when the byte is taken, written back at reconstruction
  // --------------------------------------------------------------------------
  logic [7:0] row_rdata, v;
  logic       fwd_hit, fwd_r;
  logic [7:0] fwd_d_r;

  // same entry written back on the edge it is read: use the new byte
  assign fwd_hit = s1_fire && (s1_x_r == pos_r);

  pru_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_x_r),
    .wdata (v),
    .re    (data_acc),
    .raddr (pos_r),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (data_acc) begin
        fwd_r <= fwd_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_r    <= s1_nxt;
      s1_x_r  <= pos_r;
      fwd_d_r <= v;
    end
  end

  // --------------------------------------------------------------------------
  // reconstruction: predictor from left, above and upper-left bytes
  // --------------------------------------------------------------------------
  logic [31:0] left_r, upper_r;
  logic [23:0] asm_r, asm_nxt;
  logic [7:0]  a, b, c, pred;
  logic [8:0]  ab_sum;

  assign b = s1_r.first_row ? 8'd0 : (fwd_r ? fwd_d_r : row_rdata);

  // left neighbor sits bpp bytes back in the history words
  always_comb begin
    if (s1_r.row_start) begin
      a = 8'd0;
      c = 8'd0;
    end else begin
      case (s1_r.lsel)
        2'd1:    begin a = left_r[15:8];  c = upper_r[15:8];  end
        2'd2:    begin a = left_r[23:16]; c = upper_r[23:16]; end
        2'd3:    begin a = left_r[31:24]; c = upper_r[31:24]; end
        default: begin a = left_r[7:0];   c = upper_r[7:0];   end
      endcase
    end
  end

  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_r.kind)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = ab_sum[8:1];
      FLT_PAETH: pred = paeth_pred(a, b, c);
      default:   pred = 8'd0;
    endcase
  end

  assign v = s1_r.data + pred;

  // pixel collection; gray alpha and rgba keep only the first bytes
  always_comb begin
    if (s1_r.asm_load) asm_nxt = {16'd0, v};
    else if (s1_r.asm_shift) asm_nxt = {asm_r[15:0], v};
    else asm_nxt = asm_r;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      left_r  <= s1_r.row_start ? {24'd0, v} : {left_r[23:0], v};
      upper_r <= s1_r.row_start ? {24'd0, b} : {upper_r[23:0], b};
      asm_r   <= asm_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register and palette lookup
  // --------------------------------------------------------------------------
  logic [23:0] pal_rdata;
  logic [23:0] s2_pix_r;
  logic [2:0]  s2_mode_r;
  logic        s2_end_r;
  logic        s2_load;
  logic [7:0]  g;

  assign s2_load  = s1_fire && s1_r.emit;
  assign s2_v_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_v_r);

  pru_ram #(
    .WIDTH (24),
    .DEPTH (256)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_acc),
    .waddr (in_palette_index),
    .wdata (in_palette_color),
    .re    (s2_load),
    .raddr (asm_nxt[7:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_pix_r  <= asm_nxt;
      s2_mode_r <= s1_r.mode;
      s2_end_r  <= s1_r.row_end;
    end
  end

  assign g = s2_pix_r[7:0];

  always_comb begin
    case (s2_mode_r) inside
      CM_GRAY, CM_GRAYA: out_pixel_rgb = {g, g, g};
      CM_RGB, CM_RGBA:   out_pixel_rgb = s2_pix_r;
      CM_PAL:            out_pixel_rgb = ({1'b0, g} < cfg_count_r) ? pal_rdata : 24'd0;
      default:           out_pixel_rgb = 24'd0;
    endcase
  end

  assign out_valid   = s2_v_r;
  assign out_row_end = s2_end_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_data_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc |=> s1_v_r)
    else $error("data byte did not reach reconstruction stage");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.emit |=> s2_v_r)
    else $error("finished pixel did not reach output register");

  a_fwd_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("row store forward flag without a byte in flight");

  a_no_accept_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && !out_ready |-> !in_acc)
    else $error("word accepted while pipeline is full");

endmodule

// File: rtl/pru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ram: generic simple dual-port ram
// one write port, one read port with registered data and read enable
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/tb_png_row_unfilter_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_row_unfilter_to_rgb: self-checking bench for the png row unfilter
// drives scanline, palette and image-start words with random gaps and output
// stalls, rebuilds every byte in a scoreboard and checks each pixel in order
// ----------------------------------------------------------------------------
module tb_png_row_unfilter_to_rgb;

  import pru_pkg::*;

  class pixel_scoreboard;
    typedef struct {
      logic [23:0] rgb;
      logic        row_end;
    } pixel_t;

    pixel_t      pending[$];
    bit [7:0]    row_store [4*MAX_WIDTH_DEF];
    bit [23:0]   palette [256];
    bit [31:0]   left_hist;
    bit [31:0]   upper_hist;
    int unsigned pos;
    int unsigned pix_byte;
    bit          want_filter;
    bit          first_row;
    bit [2:0]    kind;
    bit [23:0]   assembly;
    bit [10:0]   width_reg;
    bit [2:0]    mode_reg;
    bit [8:0]    count_reg;
    int unsigned errors;
    int unsigned pixels_checked;

    function new();
      width_reg   = 11'd1;
      mode_reg    = CM_RGB;
      count_reg   = 9'd0;
      want_filter = 1'b1;
      first_row   = 1'b1;
      kind        = FLT_NONE;
      clear_row();
    endfunction

    function void clear_row();
      left_hist  = '0;
      upper_hist = '0;
      pos        = 0;
      assembly   = '0;
      pix_byte   = 0;
    endfunction

    function int unsigned pixel_bytes();
      case (mode_reg)
        CM_RGB:   return 3;
        CM_GRAYA: return 2;
        CM_RGBA:  return 4;
        default:  return 1;
      endcase
    endfunction

    function int unsigned row_length();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w * pixel_bytes();
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_IMAGE_WIDTH:   width_reg = value[10:0];
        REG_COLOR_MODE:    mode_reg  = value[2:0];
        REG_PALETTE_COUNT: count_reg = value[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned paeth_pick(int a, int b, int c);
      int p, da, db, dc;
      p  = a + b - c;
      da = (p > a) ? p - a : a - p;
      db = (p > b) ? p - b : b - p;
      dc = (p > c) ? p - c : c - p;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    function void rebuild_byte(logic [7:0] data);
      int unsigned bpp, stride, x, shift, a, b, c, pred, v, g;
      bit          last_row, last_pix;
      pixel_t      px;
      bpp    = pixel_bytes();
      stride = row_length();
      x      = pos;
      if (x >= 4*MAX_WIDTH_DEF) x = 4*MAX_WIDTH_DEF - 1;
      shift = 8 * (bpp - 1);
      a = (left_hist >> shift) & 32'hFF;
      c = (upper_hist >> shift) & 32'hFF;
      b = first_row ? 0 : row_store[x];
      case (kind)
        FLT_SUB:   pred = a;
        FLT_UP:    pred = b;
        FLT_AVG:   pred = (a + b) >> 1;
        FLT_PAETH: pred = paeth_pick(a, b, c);
        default:   pred = 0;
      endcase
      v = (data + pred) & 32'hFF;
      row_store[x] = 8'(v);
      left_hist    = {left_hist[23:0], 8'(v)};
      upper_hist   = {upper_hist[23:0], 8'(b)};
      if (pix_byte == 0) assembly = 24'(v);
      else if (pix_byte < 3 && (mode_reg == CM_RGB || mode_reg == CM_RGBA))
        assembly = {assembly[15:0], 8'(v)};
      last_row = (x + 1 >= stride);
      last_pix = (pix_byte + 1 >= bpp);
      if (last_pix || last_row) begin
        g = assembly[7:0];
        case (mode_reg)
          CM_GRAY, CM_GRAYA: px.rgb = {3{assembly[7:0]}};
          CM_RGB, CM_RGBA:   px.rgb = assembly;
          CM_PAL:            px.rgb = (g < count_reg) ? palette[g] : 24'd0;
          default:           px.rgb = 24'd0;
        endcase
        px.row_end = last_row;
        pending.push_back(px);
        pix_byte = 0;
        assembly = '0;
      end else begin
        pix_byte = (pix_byte + 1) & 3;
      end
      if (last_row) begin
        want_filter = 1'b1;
        first_row   = 1'b0;
        pos         = 0;
      end else begin
        pos = x + 1;
      end
    endfunction

    function void note_word(logic [1:0] action, logic [7:0] data, logic [7:0] idx,
                            logic [23:0] color);
      case (action)
        ACT_PALETTE: palette[idx] = color;
        ACT_IMAGE: begin
          clear_row();
          want_filter = 1'b1;
          kind        = FLT_NONE;
          first_row   = 1'b1;
        end
        ACT_BYTE: begin
          if (want_filter) begin
            kind        = (data <= {5'd0, FLT_PAETH}) ? data[2:0] : FLT_NONE;
            want_filter = 1'b0;
            clear_row();
          end else begin
            rebuild_byte(data);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [23:0] rgb, logic row_end);
      pixel_t want;
      if (pending.size() == 0) begin
        $error("pixel %06h arrived with none expected", rgb);
        errors++;
        return;
      end
      want = pending.pop_front();
      pixels_checked++;
      if (rgb !== want.rgb) begin
        $error("pixel_rgb: expected %06h, got %06h", want.rgb, rgb);
        errors++;
      end
      if (row_end !== want.row_end) begin
        $error("row_end: expected %0b, got %0b", want.row_end, row_end);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action        = ACT_BYTE;
  logic [7:0]          in_data_byte     = '0;
  logic [7:0]          in_palette_index = '0;
  logic [23:0]         in_palette_color = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [23:0]         out_pixel_rgb;
  logic                out_row_end;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [PADDR_W-1:0]  paddr            = '0;
  logic [31:0]         pwdata           = '0;
  logic [31:0]         prdata;
  logic                pready;

  // idle knobs, percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // share of row slots that carry a palette write or a broken row
  int unsigned noise_pct      = 4;

  int unsigned words_sent      = 0;
  int unsigned settings_run    = 0;
  int unsigned mid_row_changes = 0;

  pixel_scoreboard pix_sb;

  png_row_unfilter_to_rgb u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls on the result channel
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // both channels observed at the same edge the handshake completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pix_sb.note_word(in_action, in_data_byte, in_palette_index, in_palette_color);
      if (out_valid && out_ready)
        pix_sb.check_pixel(out_pixel_rgb, out_row_end);
    end
  end

  // one input word; valid stays up from the previous word unless a gap is drawn
  task automatic send_word(logic [1:0] action, logic [7:0] data, logic [7:0] idx,
                           logic [23:0] color);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_action        <= action;
    in_data_byte     <= data;
    in_palette_index <= idx;
    in_palette_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // stream byte, palette fields are don't-care and get noise
  task automatic send_byte(logic [7:0] data);
    send_word(ACT_BYTE, data, 8'($urandom), 24'($urandom));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // drop valid, let every pixel drain, then cover the two-stage pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pix_sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup, access, register takes the value on the access edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pix_sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // new settings always open a new image so no row reads stale above bytes
  task automatic configure(int unsigned width, int unsigned mode, int unsigned count);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 32'(width));
    write_reg(REG_COLOR_MODE, 32'(mode));
    write_reg(REG_PALETTE_COUNT, 32'(count));
    settings_run++;
    send_word(ACT_IMAGE, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  // filter word then one row of bytes, now and then a palette write slipped in
  // or the row cut short by an image start
  task automatic send_row();
    int unsigned stride, i;
    stride = pix_sb.row_length();
    if ($urandom_range(9) < 8) send_byte(8'($urandom_range(FLT_PAETH)));
    else send_byte(8'($urandom));
    for (i = 0; i < stride; i++) begin
      if (noise_pct != 0 && $urandom_range(99) < noise_pct) begin
        if ($urandom_range(3) == 0) begin
          send_word(ACT_IMAGE, 8'($urandom), 8'($urandom), 24'($urandom));
          return;
        end
        send_word(ACT_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom));
      end
      send_byte(pick_byte());
    end
  endtask

  task automatic run_rows(int unsigned n);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < n) send_row();
  endtask

  task automatic run_phase(int unsigned width, int unsigned mode, int unsigned count,
                           int unsigned sidle, int unsigned rstall, int unsigned n);
    configure(width, mode, count);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    run_rows(n);
  endtask

  initial begin : stimulus
    logic [7:0]  directed_filters [6];
    int unsigned sidle_set [4];
    int unsigned rstall_set [4];
    int unsigned i, k;

    pix_sb = new();
    directed_filters = '{8'(FLT_NONE), 8'(FLT_SUB), 8'(FLT_UP), 8'(FLT_AVG),
                         8'(FLT_PAETH), 8'hFF};
    sidle_set  = '{0, 78, 0, 17};
    rstall_set = '{0, 0, 78, 17};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: palette corners, image start, each filter once at reset settings
    // (one rgb pixel per row), unknown filter last
    send_word(ACT_PALETTE, 8'h00, 8'h00, 24'h000000);
    send_word(ACT_PALETTE, 8'hFF, 8'hFF, 24'hFFFFFF);
    send_word(ACT_IMAGE, 8'h00, 8'h00, 24'h000000);
    foreach (directed_filters[f]) begin
      send_byte(directed_filters[f]);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
    end

    // fixed settings walking the color modes and the idle patterns
    run_phase(1, CM_GRAY, 0, 0, 0, 30);
    run_phase(5, CM_RGB, 0, 78, 0, 30);

    // fill the whole palette so any count up to 256 reads written entries
    for (i = 0; i < 256; i++)
      send_word(ACT_PALETTE, 8'($urandom), 8'(i), 24'($urandom));

    run_phase(3, CM_PAL, 256, 0, 78, 30);
    run_phase(7, CM_GRAYA, 256, 17, 17, 30);
    run_phase(4, CM_RGBA, 256, 0, 0, 30);
    run_phase(2, CM_PAL, 0, 78, 0, 20);
    run_phase(6, CM_PAL, $urandom_range(255, 1), 0, 78, 30);

    // random small settings under each idle pattern
    for (i = 0; i < 5; i++)
      run_phase($urandom_range(12, 1), $urandom_range(CM_RGBA), $urandom_range(256),
                sidle_set[i % 4], rstall_set[i % 4], 30);

    // width and mode changed partway through the first row of an image
    for (i = 0; i < 3; i++) begin
      configure($urandom_range(10, 2), $urandom_range(CM_RGBA), $urandom_range(256));
      send_idle_pct  = sidle_set[(i + 1) % 4];
      recv_stall_pct = rstall_set[(i + 1) % 4];
      send_byte(8'($urandom_range(FLT_PAETH)));
      k = $urandom_range(pix_sb.row_length() - 1, 1);
      repeat (k) send_byte(pick_byte());
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(10, 1)));
      write_reg(REG_COLOR_MODE, 32'($urandom_range(CM_RGBA)));
      mid_row_changes++;
      run_rows(20);
    end

    // drain
    wait_idle();
    if (pix_sb.pending.size() != 0) begin
      $error("%0d pixels never arrived", pix_sb.pending.size());
      pix_sb.errors++;
    end
    $display("covered %0d input words and %0d pixels over %0d settings, %0d changed mid-row",
             words_sent, pix_sb.pixels_checked, settings_run, mid_row_changes);
    $display("all five filters, every color mode, widths 1 to 12, palette count 0 to 256");
    if (pix_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
